/* hw/rtl/gpkq_pkg.sv */
package gpkq_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W       = IDX_W + 1;

  localparam int unsigned EVENT_NUM = 12;
  localparam int unsigned EVENT_W   = 4;
  localparam int unsigned DIR_NUM   = 4;
  localparam int unsigned BTN_NUM   = 8;

  localparam int unsigned JQ_DEPTH = 2;
  localparam int unsigned JQ_PTR_W = 1;
  localparam int unsigned JQ_CNT_W = 2;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic REG_LOW_LIMIT  = 1'b0;
  localparam logic REG_HIGH_LIMIT = 1'b1;

  localparam logic CMD_POLL   = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic [7:0] AXIS_REST      = 8'h7F;
  localparam logic [7:0] LOW_LIMIT_RST  = 8'd63;
  localparam logic [7:0] HIGH_LIMIT_RST = 8'd191;
  localparam logic [7:0] BUTTONS_RST    = 8'h00;

  // Button bit behind each button event, in event order A, B, X, Y, Start, Select, L, R.
  localparam logic [2:0] BUTTON_BIT [BTN_NUM] = '{
    3'd1, 3'd2, 3'd0, 3'd3, 3'd7, 3'd6, 3'd4, 3'd5
  };

  typedef struct packed {
    logic [EVENT_NUM-1:0] rise;
  } job_t;

  function automatic logic [DIR_NUM-1:0] directions(
    input logic [7:0] x,
    input logic [7:0] y,
    input logic [7:0] low_limit,
    input logic [7:0] high_limit
  );
    logic [DIR_NUM-1:0] d;
    d[0] = (y < low_limit);
    d[1] = (y > high_limit);
    d[2] = (x < low_limit);
    d[3] = (x > high_limit);
    return d;
  endfunction

endpackage

/* hw/rtl/gpkq_front.sv */
module gpkq_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [gpkq_pkg::PADDR_W-1:0] paddr_i,
  input  logic [gpkq_pkg::PDATA_W-1:0] pwdata_i,
  output logic [gpkq_pkg::PDATA_W-1:0] prdata_o,
  input  logic                        accept_i,
  input  logic                        cmd_i,
  input  logic                        report_ok_i,
  input  logic [7:0]                  x_axis_i,
  input  logic [7:0]                  y_axis_i,
  input  logic [7:0]                  buttons_i,
  output gpkq_pkg::job_t              job_o
);

  logic [7:0] low_limit_q, low_limit_d;
  logic [7:0] high_limit_q, high_limit_d;
  logic [7:0] prev_x_q, prev_x_d;
  logic [7:0] prev_y_q, prev_y_d;
  logic [7:0] prev_btn_q, prev_btn_d;
  logic       reg_sel;
  logic       cfg_we;
  logic [gpkq_pkg::DIR_NUM-1:0] dir_now;
  logic [gpkq_pkg::DIR_NUM-1:0] dir_prev;

  assign reg_sel = paddr_i[2];
  assign cfg_we  = psel_i && penable_i && pwrite_i;

  always_comb begin
    low_limit_d  = low_limit_q;
    high_limit_d = high_limit_q;
    if (cfg_we) begin
      unique case (reg_sel)
        gpkq_pkg::REG_LOW_LIMIT:  low_limit_d  = pwdata_i[7:0];
        gpkq_pkg::REG_HIGH_LIMIT: high_limit_d = pwdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gpkq_pkg::REG_LOW_LIMIT:  prdata_o = gpkq_pkg::PDATA_W'(low_limit_q);
      gpkq_pkg::REG_HIGH_LIMIT: prdata_o = gpkq_pkg::PDATA_W'(high_limit_q);
      default:                  prdata_o = '0;
    endcase
  end

  assign dir_now  = gpkq_pkg::directions(x_axis_i, y_axis_i, low_limit_q, high_limit_q);
  assign dir_prev = gpkq_pkg::directions(prev_x_q, prev_y_q, low_limit_q, high_limit_q);

  always_comb begin
    job_o.rise = '0;
    if ((cmd_i == gpkq_pkg::CMD_REPORT) && report_ok_i) begin
      job_o.rise[gpkq_pkg::DIR_NUM-1:0] = dir_now & ~dir_prev;
      for (int i = 0; i < gpkq_pkg::BTN_NUM; i++) begin
        job_o.rise[gpkq_pkg::DIR_NUM+i] = buttons_i[gpkq_pkg::BUTTON_BIT[i]] &
                                          ~prev_btn_q[gpkq_pkg::BUTTON_BIT[i]];
      end
    end
  end

  always_comb begin
    prev_x_d   = prev_x_q;
    prev_y_d   = prev_y_q;
    prev_btn_d = prev_btn_q;
    if (accept_i && (cmd_i == gpkq_pkg::CMD_REPORT)) begin
      prev_x_d   = x_axis_i;
      prev_y_d   = y_axis_i;
      prev_btn_d = buttons_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= gpkq_pkg::LOW_LIMIT_RST;
      high_limit_q <= gpkq_pkg::HIGH_LIMIT_RST;
      prev_x_q     <= gpkq_pkg::AXIS_REST;
      prev_y_q     <= gpkq_pkg::AXIS_REST;
      prev_btn_q   <= gpkq_pkg::BUTTONS_RST;
    end else begin
      low_limit_q  <= low_limit_d;
      high_limit_q <= high_limit_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      prev_btn_q   <= prev_btn_d;
    end
  end

endmodule

/* hw/rtl/gpkq_job_queue.sv */
module gpkq_job_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  gpkq_pkg::job_t wr_job_i,
  output logic           full_o,
  input  logic           rd_i,
  output gpkq_pkg::job_t rd_job_o,
  output logic           empty_o
);

  gpkq_pkg::job_t                 entry_q [gpkq_pkg::JQ_DEPTH];
  logic [gpkq_pkg::JQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [gpkq_pkg::JQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [gpkq_pkg::JQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                           do_wr;
  logic                           do_rd;

  assign full_o   = (cnt_q == gpkq_pkg::JQ_CNT_W'(gpkq_pkg::JQ_DEPTH));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

/* hw/rtl/gpkq_back.sv */
module gpkq_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_empty_i,
  input  gpkq_pkg::job_t               job_i,
  output logic                         job_rd_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic                         key_valid_o,
  output logic [gpkq_pkg::EVENT_W-1:0] key_event_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PUSH = 4'b0010,
    ST_READ = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e                               state_q, state_d;
  logic [gpkq_pkg::EVENT_NUM-1:0]       mask_q, mask_d;
  logic [gpkq_pkg::IDX_W-1:0]           head_q, head_d;
  logic [gpkq_pkg::CNT_W-1:0]           cnt_q, cnt_d;
  logic                                 hit_q, hit_d;
  logic                                 out_valid_q, out_valid_d;
  logic                                 out_key_valid_q, out_key_valid_d;
  logic [gpkq_pkg::EVENT_W-1:0]         out_event_q, out_event_d;
  logic [gpkq_pkg::EVENT_W-1:0]         store_q [gpkq_pkg::QUEUE_DEPTH];
  logic [gpkq_pkg::EVENT_W-1:0]         rdata_q;
  logic [gpkq_pkg::EVENT_W-1:0]         code;
  logic [gpkq_pkg::SUM_W-1:0]           slot_sum;
  logic [gpkq_pkg::IDX_W-1:0]           slot;
  logic [gpkq_pkg::IDX_W-1:0]           head_inc;
  logic                                 queue_full;
  logic                                 store_we;
  logic                                 store_re;
  logic                                 out_free;

  always_comb begin
    code = '0;
    for (int i = gpkq_pkg::EVENT_NUM - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        code = gpkq_pkg::EVENT_W'(i);
      end
    end
  end

  assign slot_sum = gpkq_pkg::SUM_W'(head_q) + gpkq_pkg::SUM_W'(cnt_q);
  assign slot     = (slot_sum >= gpkq_pkg::SUM_W'(gpkq_pkg::QUEUE_DEPTH)) ?
                    gpkq_pkg::IDX_W'(slot_sum - gpkq_pkg::SUM_W'(gpkq_pkg::QUEUE_DEPTH)) :
                    gpkq_pkg::IDX_W'(slot_sum);
  assign head_inc = (head_q == gpkq_pkg::IDX_W'(gpkq_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : head_q + 1'b1;
  assign queue_full = (cnt_q == gpkq_pkg::CNT_W'(gpkq_pkg::QUEUE_DEPTH));
  assign out_free   = !out_valid_q || pop_i;

  always_comb begin
    state_d         = state_q;
    mask_d          = mask_q;
    head_d          = head_q;
    cnt_d           = cnt_q;
    hit_d           = hit_q;
    out_valid_d     = out_valid_q && !pop_i;
    out_key_valid_d = out_key_valid_q;
    out_event_d     = out_event_q;
    job_rd_o        = 1'b0;
    store_we        = 1'b0;
    store_re        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_rd_o = 1'b1;
          mask_d   = job_i.rise;
          state_d  = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (mask_q == '0) begin
          state_d = ST_READ;
        end else begin
          store_we = 1'b1;
          mask_d   = mask_q & (mask_q - 1'b1);
          if (queue_full) begin
            head_d = head_inc;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_READ: begin
        hit_d   = (cnt_q != '0);
        state_d = ST_EMIT;
        if (cnt_q != '0) begin
          store_re = 1'b1;
          head_d   = head_inc;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_key_valid_d = hit_q;
          out_event_d     = hit_q ? rdata_q : '0;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q          <= mask_d;
    hit_q           <= hit_d;
    out_key_valid_q <= out_key_valid_d;
    out_event_q     <= out_event_d;
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[slot] <= code;
    end
    if (store_re) begin
      rdata_q <= store_q[head_q];
    end
  end

  assign empty_o     = !out_valid_q;
  assign key_valid_o = out_key_valid_q;
  assign key_event_o = out_event_q;

endmodule

/* hw/rtl/gamepad_report_key_event_queue_core.sv */
// Channel   Handshake                  Payload
// input     push / full                cmd_i, report_ok_i, x_axis_i, y_axis_i, buttons_i
// result    empty / pop                key_valid_o, key_event_o
// config    psel, penable, pwrite      paddr, pwdata, prdata (0x0 low limit, 0x4 high limit)
//
// The front hands the edge mask of each item to a two-entry job queue.
// The back sequencer passes idle, push, read and emit per item, pushing its n press edges (0 to 12)
// one by one, since the event store has one write port and takes one event per cycle.
// Reset is asynchronous and needs no clearing pass; the event store is never read unwritten.
// full rises while two jobs wait; a result waiting on pop stalls only the back.
module gamepad_report_key_event_queue_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gpkq_pkg::PADDR_W-1:0] paddr,
  input  logic [gpkq_pkg::PDATA_W-1:0] pwdata,
  output logic [gpkq_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         push,
  output logic                         full,
  input  logic                         cmd_i,
  input  logic                         report_ok_i,
  input  logic [7:0]                   x_axis_i,
  input  logic [7:0]                   y_axis_i,
  input  logic [7:0]                   buttons_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         key_valid_o,
  output logic [gpkq_pkg::EVENT_W-1:0] key_event_o
);

  gpkq_pkg::job_t front_job;
  gpkq_pkg::job_t back_job;
  logic           accept;
  logic           job_rd;
  logic           job_empty;

  assign pready = 1'b1;
  assign accept = push && !full;

  gpkq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .report_ok_i (report_ok_i),
    .x_axis_i    (x_axis_i),
    .y_axis_i    (y_axis_i),
    .buttons_i   (buttons_i),
    .job_o       (front_job)
  );

  gpkq_job_queue u_job_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push),
    .wr_job_i (front_job),
    .full_o   (full),
    .rd_i     (job_rd),
    .rd_job_o (back_job),
    .empty_o  (job_empty)
  );

  gpkq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (back_job),
    .job_rd_o    (job_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .key_valid_o (key_valid_o),
    .key_event_o (key_event_o)
  );

endmodule

/* hw/rtl/gpkq_checker.sv */
module gpkq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic                         key_valid_o,
  input logic [gpkq_pkg::EVENT_W-1:0] key_event_o
);

  // A result that is not taken stays on the ports unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(key_valid_o) && $stable(key_event_o))
    else $error("waiting result changed before its transfer");

  // A result without an event carries event code zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !key_valid_o |-> key_event_o == '0)
    else $error("empty pop result carries a nonzero event");

  // Event codes stay within the twelve defined events.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && key_valid_o |-> key_event_o < gpkq_pkg::EVENT_W'(gpkq_pkg::EVENT_NUM))
    else $error("event code out of range");

  // Reset leaves no result pending.
  assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result pending after reset");

  // The input side only fills up through an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full && !push |=> !full)
    else $error("full rose without an input transfer");

endmodule

bind gamepad_report_key_event_queue_core gpkq_checker u_gpkq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .key_valid_o (key_valid_o),
  .key_event_o (key_event_o)
);
